// File: rtl/core/lzwd_pkg.sv
`default_nettype none
package lzwd_pkg;

  localparam int HIST_DEPTH = 4096;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int WORD_W     = 16;
  localparam int OFFSET_W   = 12;
  localparam int LEN_W      = 5;
  localparam int FLAGS_W    = 5;
  localparam int MATCH_MIN  = 3;
  localparam int FLAGS_PER_WORD = 16;

  localparam logic [WORD_W-1:0] FRAME_PIXELS_RESET = 16'd49152;

  typedef struct packed {
    logic load_flags;
    logic shift_flags;
    logic emit_lit;
    logic start_copy;
    logic emit_copy;
    logic read_next;
    logic clear_step;
  } lzwd_cmd_t;

  typedef struct packed {
    logic flags_empty;
    logic flag_top;
    logic rem_last;
    logic slot_free;
    logic clear_last;
  } lzwd_status_t;

endpackage
`default_nettype wire

// File: rtl/core/lzwd_ctrl.sv
`default_nettype none
module lzwd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire lzwd_pkg::lzwd_status_t status,
  output lzwd_pkg::lzwd_cmd_t       cmd
);
  import lzwd_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_COPY  = 3'b100
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE) && status.slot_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (status.flags_empty) begin
            cmd.load_flags = 1'b1;
          end else begin
            cmd.shift_flags = 1'b1;
            if (status.flag_top) begin
              cmd.emit_lit = 1'b1;
            end else begin
              cmd.start_copy = 1'b1;
              state_next     = ST_COPY;
            end
          end
        end
      end
      ST_COPY: begin
        if (status.slot_free) begin
          cmd.emit_copy = 1'b1;
          if (status.rem_last) state_next = ST_IDLE;
          else cmd.read_next = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

endmodule
`default_nettype wire

// File: rtl/core/lzwd_datapath.sv
`default_nettype none
module lzwd_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [lzwd_pkg::WORD_W-1:0] compressed_word,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [lzwd_pkg::WORD_W-1:0] frame_pixels,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [lzwd_pkg::WORD_W-1:0]      pixel,
  output logic                            last_of_run,
  output logic                            end_of_frame,
  input  wire lzwd_pkg::lzwd_cmd_t        cmd,
  output lzwd_pkg::lzwd_status_t          status
);
  import lzwd_pkg::*;

  logic [WORD_W-1:0]  history [HIST_DEPTH];
  logic [WORD_W-1:0]  rd_data;
  logic [WORD_W-1:0]  frame_len;
  logic [WORD_W-1:0]  flag_bits;
  logic [FLAGS_W-1:0] flags_left;
  logic [HIST_AW-1:0] write_index;
  logic [HIST_AW-1:0] copy_source;
  logic [LEN_W-1:0]   copy_remaining;
  logic [WORD_W-1:0]  pixel_count;
  logic [HIST_AW-1:0] clr_addr;

  logic               we, re, emit;
  logic [HIST_AW-1:0] waddr, raddr, src0;
  logic [WORD_W-1:0]  wdata;
  logic [WORD_W-1:0]  count_next;
  logic               eof;

  assign cfg_ready = 1'b1;

  // match start lies offset+1 words behind the write index
  assign src0 = write_index - HIST_AW'(compressed_word[OFFSET_W-1:0]) - HIST_AW'(1);

  assign emit  = cmd.emit_lit || cmd.emit_copy;
  assign we    = cmd.clear_step || emit;
  assign waddr = cmd.clear_step ? clr_addr : write_index;
  assign wdata = cmd.clear_step ? '0 : (cmd.emit_lit ? compressed_word : rd_data);
  assign re    = cmd.start_copy || cmd.read_next;
  assign raddr = cmd.start_copy ? src0 : copy_source;

  assign count_next = pixel_count + WORD_W'(1);
  assign eof        = (count_next >= frame_len) || (count_next == '0);

  assign status.flags_empty = (flags_left == '0);
  assign status.flag_top    = flag_bits[WORD_W-1];
  assign status.rem_last    = (copy_remaining == LEN_W'(1));
  assign status.slot_free   = !out_valid || out_ready;
  assign status.clear_last  = (clr_addr == HIST_AW'(HIST_DEPTH - 1));

  // history memory, write-first so an offset of zero sees the word just stored
  always_ff @(posedge clk) begin
    if (we) history[waddr] <= wdata;
    if (re) rd_data <= (we && (waddr == raddr)) ? wdata : history[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_len      <= FRAME_PIXELS_RESET;
      flag_bits      <= '0;
      flags_left     <= '0;
      write_index    <= '0;
      copy_source    <= '0;
      copy_remaining <= '0;
      pixel_count    <= '0;
      clr_addr       <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid) frame_len <= frame_pixels;
      if (cmd.clear_step) clr_addr <= clr_addr + HIST_AW'(1);
      if (cmd.load_flags) begin
        flag_bits  <= compressed_word;
        flags_left <= FLAGS_W'(FLAGS_PER_WORD);
      end else if (cmd.shift_flags) begin
        flag_bits  <= {flag_bits[WORD_W-2:0], 1'b0};
        flags_left <= flags_left - FLAGS_W'(1);
      end
      if (cmd.start_copy) begin
        copy_source    <= src0 + HIST_AW'(1);
        copy_remaining <= LEN_W'(compressed_word[WORD_W-1:OFFSET_W]) + LEN_W'(MATCH_MIN);
      end else begin
        if (cmd.read_next) copy_source <= copy_source + HIST_AW'(1);
        if (cmd.emit_copy) copy_remaining <= copy_remaining - LEN_W'(1);
      end
      if (emit) begin
        write_index <= write_index + HIST_AW'(1);
        pixel_count <= eof ? '0 : count_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel        <= wdata;
      last_of_run  <= cmd.emit_lit || status.rem_last;
      end_of_frame <= eof;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/lzss_word_decompressor_unit.sv
// lzss word decompressor
// in channel: in_valid / in_ready with compressed_word, one 16-bit word per
// request: a flag word, a literal pixel or a match token, in stream order
// out channel: out_valid / out_ready with pixel, last_of_run and end_of_frame
// cfg channel: cfg_valid / cfg_ready with frame_pixels, always ready
// a flag word gives no pixel
// a literal shows on the output in the cycle after it is taken
// a match of 3 to 18 words holds the input until its last pixel is copied;
// its first pixel goes from the history read register to the output
// register, then one pixel a cycle follows while that register can be reloaded
// after reset the 4096-word history is cleared one word a cycle, during
// which no word is taken; configuration writes are taken as ever
// the output register holds while out_ready is low; the block then stops
// copying and takes no new word until the register can be reloaded
`default_nettype none
module lzss_word_decompressor_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [lzwd_pkg::WORD_W-1:0] compressed_word,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [lzwd_pkg::WORD_W-1:0] frame_pixels,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [lzwd_pkg::WORD_W-1:0]      pixel,
  output logic                             last_of_run,
  output logic                             end_of_frame
);
  import lzwd_pkg::*;

  lzwd_cmd_t    cmd;
  lzwd_status_t status;

  lzwd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lzwd_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .compressed_word (compressed_word),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .frame_pixels    (frame_pixels),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .pixel           (pixel),
    .last_of_run     (last_of_run),
    .end_of_frame    (end_of_frame),
    .cmd             (cmd),
    .status          (status)
  );

endmodule
`default_nettype wire

// File: dv/tb_lzss_word_decompressor_unit.sv
`timescale 1ns / 100ps
module tb_lzss_word_decompressor_unit;
  import lzwd_pkg::*;

  localparam int N_DIR          = 18;
  localparam int N_PHASE        = 7;
  localparam int WORDS_PER_PHASE = 60;
  localparam int SETTLE_CYCLES  = 30;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int IDLE_PCT       = 18;

  typedef struct packed {
    logic [WORD_W-1:0] pixel;
    logic              last;
    logic              eof;
  } pixel_beat_t;

  // typed rows carry n_pix copies of pix, the last one flagged
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              typed;
    logic [LEN_W-1:0]  n_pix;
    logic [WORD_W-1:0] pix;
  } dir_row_t;

  localparam dir_row_t DIR_TBL [N_DIR] = '{
    '{16'h3CAA, 1'b1, 5'd0,  16'h0000},  // flag word
    '{16'hF000, 1'b1, 5'd18, 16'h0000},  // longest match, reaches behind the first stored word
    '{16'h0FFF, 1'b1, 5'd3,  16'h0000},  // largest offset, lands on unwritten history
    '{16'hFFFF, 1'b1, 5'd1,  16'hFFFF},
    '{16'h0000, 1'b1, 5'd1,  16'h0000},
    '{16'hA5A5, 1'b1, 5'd1,  16'hA5A5},
    '{16'h5A5A, 1'b1, 5'd1,  16'h5A5A},
    '{16'h0000, 1'b1, 5'd3,  16'h5A5A},  // shortest match, offset zero, overlapping
    '{16'h1001, 1'b0, 5'd0,  16'h0000},
    '{16'h8000, 1'b1, 5'd1,  16'h8000},
    '{16'h2003, 1'b0, 5'd0,  16'h0000},
    '{16'h0001, 1'b1, 5'd1,  16'h0001},
    '{16'hF00F, 1'b0, 5'd0,  16'h0000},
    '{16'h7FFF, 1'b1, 5'd1,  16'h7FFF},
    '{16'h5010, 1'b0, 5'd0,  16'h0000},
    '{16'h1234, 1'b1, 5'd1,  16'h1234},
    '{16'h3FFE, 1'b0, 5'd0,  16'h0000},
    '{16'h0000, 1'b1, 5'd0,  16'h0000}   // flag word of all matches
  };

  localparam logic [WORD_W-1:0] FRAME_SET [N_PHASE] = '{
    16'd1, 16'd0, 16'd65535, 16'd37, 16'd100, 16'd3, 16'd0
  };

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [WORD_W-1:0] compressed_word;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [WORD_W-1:0] frame_pixels;
  logic              out_valid;
  logic              out_ready;
  logic [WORD_W-1:0] pixel;
  logic              last_of_run;
  logic              end_of_frame;

  // decoder state mirror
  logic [WORD_W-1:0]  hist_mem [HIST_DEPTH];
  logic [HIST_AW-1:0] wr_ptr;
  logic [WORD_W-1:0]  flag_reg;
  logic [FLAGS_W-1:0] flag_cnt;
  logic [WORD_W-1:0]  pix_cnt;
  logic [WORD_W-1:0]  frame_len;

  pixel_beat_t pixel_expect_q [$];
  pixel_beat_t want_beat;
  int          err_count;
  int          stall_cycles;
  bit          steady;

  lzss_word_decompressor_unit u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .compressed_word (compressed_word),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .frame_pixels    (frame_pixels),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .pixel           (pixel),
    .last_of_run     (last_of_run),
    .end_of_frame    (end_of_frame)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic clear_decoder();
    for (int i = 0; i < HIST_DEPTH; i++) hist_mem[i] = '0;
    wr_ptr    = '0;
    flag_reg  = '0;
    flag_cnt  = '0;
    pix_cnt   = '0;
    frame_len = FRAME_PIXELS_RESET;
  endtask

  task automatic put_pixel(input logic [WORD_W-1:0] v, input logic last);
    logic [WORD_W-1:0] nxt;
    logic              eof;
    nxt = pix_cnt + WORD_W'(1);
    eof = (nxt >= frame_len) || (nxt == '0);
    pix_cnt = eof ? '0 : nxt;
    hist_mem[wr_ptr] = v;
    wr_ptr = wr_ptr + HIST_AW'(1);
    pixel_expect_q.push_back('{pixel: v, last: last, eof: eof});
  endtask

  task automatic decode_word(input logic [WORD_W-1:0] w, output int n_pix);
    logic [HIST_AW-1:0] src;
    logic [LEN_W-1:0]   left;
    logic               is_lit;
    n_pix = 0;
    if (flag_cnt == '0) begin
      flag_reg = w;
      flag_cnt = FLAGS_W'(FLAGS_PER_WORD);
    end else begin
      is_lit   = flag_reg[WORD_W-1];
      flag_reg = flag_reg << 1;
      flag_cnt = flag_cnt - FLAGS_W'(1);
      if (is_lit) begin
        put_pixel(w, 1'b1);
        n_pix = 1;
      end else begin
        src  = wr_ptr - HIST_AW'(w[OFFSET_W-1:0]) - HIST_AW'(1);
        left = LEN_W'(w[WORD_W-1:OFFSET_W]) + LEN_W'(MATCH_MIN);
        while (left != '0) begin
          left = left - LEN_W'(1);
          put_pixel(hist_mem[src], left == '0);
          src = src + HIST_AW'(1);
          n_pix++;
        end
      end
    end
  endtask

  // next word follows the flag state so most streams are well formed
  function automatic logic [WORD_W-1:0] pick_word();
    logic [WORD_W-1:0] w;
    w = WORD_W'($urandom);
    if ($urandom_range(19) != 0) begin
      if (flag_cnt == '0) begin
        if ($urandom_range(7) == 0) w = $urandom_range(1) ? '1 : '0;
      end else if (!flag_reg[WORD_W-1]) begin
        if ($urandom_range(7) == 0) w[OFFSET_W-1:0] = OFFSET_W'($urandom_range(4095));
        else w[OFFSET_W-1:0] = OFFSET_W'($urandom_range(40));
      end
    end
    return w;
  endfunction

  task automatic send_word(input logic [WORD_W-1:0] w, output int n_pix);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid        <= 1'b1;
    compressed_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_word(w, n_pix);
  endtask

  // hold the input until every expected pixel is out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pixel_expect_q.size() != 0);
  endtask

  task automatic write_frame_len(input logic [WORD_W-1:0] v);
    cfg_valid    <= 1'b1;
    frame_pixels <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    frame_len = v;
  endtask

  function automatic void check_field(input string what, input logic [WORD_W-1:0] want,
                                      input logic [WORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pixel_expect_q.size() == 0) begin
          $display("%0t: pixel %h with none expected", $time, pixel);
          err_count++;
        end else begin
          want_beat = pixel_expect_q.pop_front();
          check_field("pixel", want_beat.pixel, pixel);
          check_field("last_of_run", WORD_W'(want_beat.last), WORD_W'(last_of_run));
          check_field("end_of_frame", WORD_W'(want_beat.eof), WORD_W'(end_of_frame));
        end
      end
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int               n_pix;
    dir_row_t         row;
    logic [WORD_W-1:0] len;
    err_count       = 0;
    stall_cycles    = 0;
    steady          = 1'b0;
    rst             <= 1'b1;
    in_valid        <= 1'b0;
    compressed_word <= '0;
    cfg_valid       <= 1'b0;
    frame_pixels    <= '0;
    out_ready       <= 1'b0;
    clear_decoder();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed rows at the reset frame length
    for (int r = 0; r < N_DIR; r++) begin
      row = DIR_TBL[r];
      send_word(row.word, n_pix);
      if (row.typed) begin
        repeat (n_pix) void'(pixel_expect_q.pop_back());
        for (int j = 0; j < row.n_pix; j++)
          pixel_expect_q.push_back('{pixel: row.pix, last: j == row.n_pix - 1, eof: 1'b0});
      end
    end
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    for (int ph = 0; ph < N_PHASE; ph++) begin
      len = (ph == N_PHASE - 1) ? WORD_W'($urandom_range(1, 300)) : FRAME_SET[ph];
      write_frame_len(len);
      steady = (ph == 3);
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        if (ph == 4 && k == 30) wait_drained();
        send_word(pick_word(), n_pix);
      end
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
